>>> hdl/gpr_pkg.sv
// Shared types, constants and tap-sum functions for the Gaussian pyramid reduce block.
// No dependencies; imported by the top level and the port checker.
package gpr_pkg;

    localparam int PIX_W           = 16;
    localparam int SUM_W           = 20;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int MIN_DIM         = 4;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // Tap position of an output sample along one axis
    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_MID   = 2'd1,
        MODE_LAST  = 2'd2
    } tap_mode_t;

    function automatic logic signed [SUM_W-1:0] sext(input logic signed [PIX_W-1:0] a);
        return $signed({{(SUM_W-PIX_W){a[PIX_W-1]}}, a});
    endfunction

    // 1-4-6-4-1 sum
    function automatic logic signed [SUM_W-1:0] tap_center(
        input logic signed [PIX_W-1:0] a,
        input logic signed [PIX_W-1:0] b,
        input logic signed [PIX_W-1:0] c,
        input logic signed [PIX_W-1:0] d,
        input logic signed [PIX_W-1:0] e
    );
        logic signed [SUM_W-1:0] ea, eb, ec, ed, ee;
        ea = sext(a);
        eb = sext(b);
        ec = sext(c);
        ed = sext(d);
        ee = sext(e);
        return ea + (eb <<< 2) + (ec <<< 2) + (ec <<< 1) + (ed <<< 2) + ee;
    endfunction

    // 11-4-1 sum at an image border
    function automatic logic signed [SUM_W-1:0] tap_edge(
        input logic signed [PIX_W-1:0] p11,
        input logic signed [PIX_W-1:0] p4,
        input logic signed [PIX_W-1:0] p1
    );
        logic signed [SUM_W-1:0] ea, eb, ec;
        ea = sext(p11);
        eb = sext(p4);
        ec = sext(p1);
        return (ea <<< 3) + (ea <<< 1) + ea + (eb <<< 2) + ec;
    endfunction

endpackage

>>> hdl/gaussian_pyramid_reduce.sv
// Gaussian pyramid reduce, one level, top level.
// Depends on gpr_pkg (widths, register indexes, tap-sum functions).

// Takes signed 16-bit pixels in raster order, one transaction per clock, and
// returns the reduced image (half width, half height, rounded down) in raster
// order with row_end / frame_end marks. Each axis applies the 1-4-6-4-1 kernel
// with a floor shift by 4, horizontal first, keeping every second sample; border
// outputs repeat the center sample (weights 11-4-1). Throughput is one input
// pixel per cycle, sustained while out_ready keeps up: it is set by the line
// store, a single memory that takes one read and one write-back per cycle. A
// reduced pixel goes from the stage 1 registers into the output register when
// stage 1 advances. Pipeline:
//   stage 0 - position counters, pixel window, horizontal tap sum, line store read
//   stage 1 - vertical tap sum on the four stored filtered rows, write-back
//   output  - result register, holds while out_ready is low
// A pixel that yields no horizontal output skips stage 1. The line store holds
// garbage after reset; within a frame every entry is written before use.
// frame_width / frame_height are clamped to [4, MAX_*] and should only be
// written with the pipeline empty. The config channel is always ready.
module gaussian_pyramid_reduce
    #(
        parameter int MAX_WIDTH  = gpr_pkg::DEF_MAX_WIDTH,
        parameter int MAX_HEIGHT = gpr_pkg::DEF_MAX_HEIGHT
    )
    (
        input  logic                                 clk,
        input  logic                                 rst_n,
        // pixel input
        input  logic                                 in_valid,
        output logic                                 in_ready,
        input  logic signed [gpr_pkg::PIX_W-1:0]     pixel_in,
        // reduced output
        output logic                                 out_valid,
        input  logic                                 out_ready,
        output logic signed [gpr_pkg::PIX_W-1:0]     pixel_out,
        output logic                                 row_end,
        output logic                                 frame_end,
        // register writes
        input  logic                                 cfg_valid,
        output logic                                 cfg_ready,
        input  logic [gpr_pkg::CFG_IDX_W-1:0]        cfg_index,
        input  logic [gpr_pkg::CFG_DATA_W-1:0]       cfg_data
    );
    import gpr_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int RW         = $clog2(MAX_HEIGHT + 1);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int ENTRY_W    = 4 * PIX_W;

    // ---------------- configuration ----------------
    logic [CFG_DATA_W-1:0] width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to the supported range
    logic [31:0]   w_raw, h_raw;
    logic [CW-1:0] w_eff, w_half;
    logic [RW-1:0] h_eff, h_half;

    always_comb
    begin
        w_raw = 32'(width_reg);
        h_raw = 32'(height_reg);
        if (w_raw < 32'(MIN_DIM))
            w_eff = CW'(MIN_DIM);
        else if (w_raw > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(w_raw);
        if (h_raw < 32'(MIN_DIM))
            h_eff = RW'(MIN_DIM);
        else if (h_raw > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(h_raw);
        w_half = w_eff >> 1;
        h_half = h_eff >> 1;
    end

    // ---------------- stage 0 ----------------
    logic [CW-1:0]            col_cnt_reg, col_cnt_next;
    logic [RW-1:0]            row_cnt_reg;
    logic signed [PIX_W-1:0]  win_reg [4];

    logic [CW-1:0]            col_cur, col_half;
    logic [RW-1:0]            row_step, row_cur, row_half;
    logic                     have_c, have_r;
    tap_mode_t                mode_c, mode_r;
    logic [AW-1:0]            c_addr;
    logic signed [SUM_W-1:0]  h_sum;
    logic signed [PIX_W-1:0]  hv;
    logic                     in_fire;

    // stage 1 / output handshake
    logic                     s1_valid_reg;
    logic                     s1_adv;
    logic                     s1_have_r_reg;
    logic                     out_valid_reg;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        // position of this pixel, wrapping at the frame edges
        if (col_cnt_reg >= w_eff)
        begin
            col_cur  = '0;
            row_step = RW'(row_cnt_reg + 1'b1);
        end
        else
        begin
            col_cur  = col_cnt_reg;
            row_step = row_cnt_reg;
        end
        row_cur      = (row_step >= h_eff) ? '0 : row_step;
        col_cnt_next = CW'(col_cur + 1'b1);
        col_half     = col_cur >> 1;
        row_half     = row_cur >> 1;

        // column: even positions from 2 give outputs, last output at 2*(W/2)-1
        have_c = 1'b0;
        mode_c = MODE_MID;
        c_addr = AW'(col_half - CW'(1));
        if (col_cur >= CW'(2) && !col_cur[0] && col_half < w_half)
        begin
            have_c = 1'b1;
            mode_c = (col_half == CW'(1)) ? MODE_FIRST : MODE_MID;
        end
        else if (col_cur == CW'((w_half << 1) - CW'(1)))
        begin
            have_c = 1'b1;
            mode_c = MODE_LAST;
            c_addr = AW'(w_half - CW'(1));
        end

        have_r = 1'b0;
        mode_r = MODE_MID;
        if (row_cur >= RW'(2) && !row_cur[0] && row_half < h_half)
        begin
            have_r = 1'b1;
            mode_r = (row_half == RW'(1)) ? MODE_FIRST : MODE_MID;
        end
        else if (row_cur == RW'((h_half << 1) - RW'(1)))
        begin
            have_r = 1'b1;
            mode_r = MODE_LAST;
        end

        case (mode_c)
            MODE_FIRST: h_sum = tap_edge(win_reg[1], win_reg[0], pixel_in);
            MODE_MID:   h_sum = tap_center(win_reg[3], win_reg[2], win_reg[1],
                                           win_reg[0], pixel_in);
            MODE_LAST:  h_sum = tap_edge(win_reg[0], win_reg[1], win_reg[2]);
            default:    h_sum = '0;
        endcase
        hv = h_sum[SUM_W-1:SUM_W-PIX_W];   // floor shift by 4
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            win_reg[0]  <= '0;
            win_reg[1]  <= '0;
            win_reg[2]  <= '0;
            win_reg[3]  <= '0;
        end
        else if (in_fire)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cur;
            win_reg[3]  <= win_reg[2];
            win_reg[2]  <= win_reg[1];
            win_reg[1]  <= win_reg[0];
            win_reg[0]  <= pixel_in;
        end
    end

    // ---------------- line store ----------------
    // entry = {row n, row n-1, row n-2, row n-3}, newest in the top lane
    logic [ENTRY_W-1:0] line_mem [LINE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s0_load;

    assign s0_load = in_fire && have_c;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_addr_reg] <= wr_data;
        if (s0_load)
            rd_data_reg <= line_mem[c_addr];
    end

    // read and write of the same entry in one cycle: take the written data
    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            fwd_reg      <= s1_adv && (s1_addr_reg == c_addr);
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------- stage 1 ----------------
    logic signed [PIX_W-1:0]  s1_hv_reg;
    tap_mode_t                s1_mode_r_reg;
    logic                     s1_row_end_reg, s1_frame_end_reg;
    logic [ENTRY_W-1:0]       line_entry;
    logic signed [PIX_W-1:0]  s0, s1, s2, s3;
    logic signed [SUM_W-1:0]  v_sum;

    assign s1_adv   = s1_valid_reg && (!s1_have_r_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s0_load)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            s1_hv_reg        <= hv;
            s1_addr_reg      <= c_addr;
            s1_have_r_reg    <= have_r;
            s1_mode_r_reg    <= mode_r;
            s1_row_end_reg   <= (mode_c == MODE_LAST);
            s1_frame_end_reg <= (mode_c == MODE_LAST) && (mode_r == MODE_LAST);
        end
    end

    always_comb
    begin
        line_entry = fwd_reg ? fwd_data_reg : rd_data_reg;
        s0 = line_entry[PIX_W-1:0];
        s1 = line_entry[2*PIX_W-1:PIX_W];
        s2 = line_entry[3*PIX_W-1:2*PIX_W];
        s3 = line_entry[4*PIX_W-1:3*PIX_W];
        case (s1_mode_r_reg)
            MODE_FIRST: v_sum = tap_edge(s2, s3, s1_hv_reg);
            MODE_MID:   v_sum = tap_center(s0, s1, s2, s3, s1_hv_reg);
            MODE_LAST:  v_sum = tap_edge(s3, s2, s1);
            default:    v_sum = '0;
        endcase
        wr_data = {s1_hv_reg, s3, s2, s1};
    end

    // ---------------- output register ----------------
    logic signed [PIX_W-1:0] pixel_out_reg;
    logic                    row_end_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_have_r_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_have_r_reg)
        begin
            pixel_out_reg <= v_sum[SUM_W-1:SUM_W-PIX_W];
            row_end_reg   <= s1_row_end_reg;
            frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> hdl/gpr_checker.sv
// Port-level checker for gaussian_pyramid_reduce, bound to the top level.
// Depends on gpr_pkg for field widths.
module gpr_checker
    (
        input logic                             clk,
        input logic                             rst_n,
        input logic                             in_valid,
        input logic                             in_ready,
        input logic                             out_valid,
        input logic                             out_ready,
        input logic signed [gpr_pkg::PIX_W-1:0] pixel_out,
        input logic                             row_end,
        input logic                             frame_end
    );
    import gpr_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out)
            && $stable(row_end) && $stable(frame_end))
        else $error("output changed while stalled");

    // frame end only on the last pixel of a row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    // a rising out_valid follows an earlier accepted input transaction
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without input transaction");

    // with the output side empty, input is never blocked
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind gaussian_pyramid_reduce gpr_checker u_gpr_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gaussian_pyramid_reduce: pixel streams against a built-in predictor.
// Depends on gpr_pkg and the gaussian_pyramid_reduce RTL.

module tb;

    import gpr_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    // Accepted pixel through stage 1 to the output register, plus margin
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    // Longest legal quiet stretch is the receiver hold-off; take it ten times over
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_PRINTED     = 100;
    localparam int STORE_COLS      = DEF_MAX_WIDTH / 2;

    typedef struct {
        logic signed [PIX_W-1:0] pixel;
        logic                    row_end;
        logic                    frame_end;
    } reduced_pix_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [PIX_W-1:0] pixel_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [PIX_W-1:0] pixel_out;
    logic                    row_end;
    logic                    frame_end;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Predictor state: register copies, raster position, pixel history, filtered rows
    logic [CFG_DATA_W-1:0]   cfg_width;
    logic [CFG_DATA_W-1:0]   cfg_height;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic signed [PIX_W-1:0] recent_px [4];            // [0] is the newest pixel
    logic signed [PIX_W-1:0] filt_rows [STORE_COLS][4]; // [3] is the newest row

    reduced_pix_t            pending_reduced [$];
    reduced_pix_t            want;
    int unsigned             mismatch_count;
    int unsigned             quiet_cycles;
    int unsigned             burst_left;
    bit                      sender_gaps_on;
    bit                      hold_off_req;

    gaussian_pyramid_reduce dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advances the predictor by one accepted pixel; returns 1 when a reduced
    // pixel is due, with its fields in res.
    function automatic bit predict_reduce(input logic signed [PIX_W-1:0] px,
                                          output reduced_pix_t res);
        int unsigned w, h, w2, h2, col, row, c, r, k;
        int          hsum, vsum, hv;
        bit          have_c, have_r;
        tap_mode_t   mode_c, mode_r;

        w  = clamp_dim(32'(cfg_width), DEF_MAX_WIDTH);
        h  = clamp_dim(32'(cfg_height), DEF_MAX_HEIGHT);
        w2 = w / 2;
        h2 = h / 2;
        have_c = 1'b0;
        have_r = 1'b0;
        c = 0;
        r = 0;
        mode_c = MODE_MID;
        mode_r = MODE_MID;
        res.pixel     = '0;
        res.row_end   = 1'b0;
        res.frame_end = 1'b0;

        // position wraps lazily, so a size change takes effect here
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        col = col_pos;
        row = row_pos;

        // reduced column c is centered on input column 2c, emitted two columns later
        if (col >= 2 && (col % 2) == 0 && (col - 2) / 2 < w2 - 1)
        begin
            c = (col - 2) / 2;
            have_c = 1'b1;
            if (c == 0)
                mode_c = MODE_FIRST;
        end
        else if (col == 2 * w2 - 1)
        begin
            c = w2 - 1;
            have_c = 1'b1;
            mode_c = MODE_LAST;
        end
        if (row >= 2 && (row % 2) == 0 && (row - 2) / 2 < h2 - 1)
        begin
            r = (row - 2) / 2;
            have_r = 1'b1;
            if (r == 0)
                mode_r = MODE_FIRST;
        end
        else if (row == 2 * h2 - 1)
        begin
            r = h2 - 1;
            have_r = 1'b1;
            mode_r = MODE_LAST;
        end

        if (have_c)
        begin
            case (mode_c)
                MODE_FIRST: hsum = 11 * recent_px[1] + 4 * recent_px[0] + px;
                MODE_MID:   hsum = recent_px[3] + 4 * recent_px[2] + 6 * recent_px[1]
                                   + 4 * recent_px[0] + px;
                default:    hsum = recent_px[2] + 4 * recent_px[1] + 11 * recent_px[0];
            endcase
            hv = hsum >>> 4;

            if (have_r)
            begin
                case (mode_r)
                    MODE_FIRST: vsum = 11 * filt_rows[c][2] + 4 * filt_rows[c][3] + hv;
                    MODE_MID:   vsum = filt_rows[c][0] + 4 * filt_rows[c][1]
                                       + 6 * filt_rows[c][2] + 4 * filt_rows[c][3] + hv;
                    default:    vsum = filt_rows[c][1] + 4 * filt_rows[c][2]
                                       + 11 * filt_rows[c][3];
                endcase
                res.pixel     = PIX_W'(vsum >>> 4);
                res.row_end   = (c == w2 - 1);
                res.frame_end = (c == w2 - 1) && (r == h2 - 1);
            end
            for (k = 0; k < 3; k++)
                filt_rows[c][k] = filt_rows[c][k + 1];
            filt_rows[c][3] = PIX_W'(hv);
        end

        for (k = 3; k > 0; k--)
            recent_px[k] = recent_px[k - 1];
        recent_px[0] = px;
        col_pos = col + 1;
        return have_c && have_r;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    function automatic logic signed [PIX_W-1:0] rand_pixel();
        // full-scale values show up often so border sums hit their limits
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR @%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // One pixel transaction; while sender_gaps_on is set, the sender runs in bursts with random gaps between.
    task automatic send_pixel(input logic signed [PIX_W-1:0] px);
        int unsigned  gap;
        reduced_pix_t res;

        gap = 0;
        if (sender_gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left != 0)
            burst_left--;
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (!in_ready);
        if (predict_reduce(px, res))
            pending_reduced.push_back(res);
    endtask

    // Stops the sender and waits for every expected pixel plus the pipeline tail.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reduced.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = value;
        else if (idx == REG_FRAME_HEIGHT)
            cfg_height = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame_dims(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First frame after reset. Four rows at width 32 write all four slots of
    // the first 16 line-store columns, which covers every column that the
    // narrower frames of the later tests read.
    task automatic test_wide_frame();
        set_frame_dims(11'd32, 11'd4);
        repeat (32 * 4) send_pixel(rand_pixel());
        wait_results_drained();
    endtask

    // Smallest frame (sizes below the minimum clamp up to 4x4) with full-scale
    // pixels: saturated flats and alternating extremes hit the sum limits.
    task automatic test_pixel_extremes();
        logic signed [PIX_W-1:0] corner_px [16] = '{
            16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
            16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
            16'sh8000, 16'sh7FFF, 16'sh0001, 16'shFFFF,
            16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh5555
        };
        set_frame_dims(11'd0, 11'd3);
        foreach (corner_px[i])
            send_pixel(corner_px[i]);
        wait_results_drained();
    endtask

    // Small random sizes (odd ones leave a trailing row/column unused), one or
    // two whole frames per setting, now and then a size below the minimum.
    task automatic test_random_frames();
        int unsigned sent, w_reg, h_reg, n;
        sent = 0;
        while (sent < 250)
        begin
            w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
            h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
            set_frame_dims(CFG_DATA_W'(w_reg), CFG_DATA_W'(h_reg));
            n = clamp_dim(w_reg, DEF_MAX_WIDTH) * clamp_dim(h_reg, DEF_MAX_HEIGHT)
                * $urandom_range(1, 2);
            repeat (n) send_pixel(rand_pixel());
            sent += n;
            wait_results_drained();
        end
    endtask

    // Sizes change with the raster position somewhere inside a frame; the
    // counters carry over and wrap against the new size. Starts with both
    // registers far above the maximum.
    task automatic test_register_change_mid_frame();
        int unsigned k;
        set_frame_dims(11'd2047, 11'd1500);
        repeat (70) send_pixel(rand_pixel());
        wait_results_drained();
        for (k = 0; k < 8; k++)
        begin
            set_frame_dims(CFG_DATA_W'($urandom_range(4, 12)),
                           CFG_DATA_W'($urandom_range(4, 10)));
            repeat ($urandom_range(5, 60)) send_pixel(rand_pixel());
            wait_results_drained();
        end
    endtask

    // Receiver holds off for a long stretch while the sender streams with no
    // gaps; the block must fill and stall its input without losing pixels.
    task automatic test_output_backpressure();
        set_frame_dims(11'd16, 11'd8);
        sender_gaps_on = 1'b0;
        hold_off_req = 1'b1;
        repeat (16 * 8) send_pixel(rand_pixel());
        sender_gaps_on = 1'b1;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_in       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        mismatch_count = 0;
        burst_left     = 0;
        sender_gaps_on = 1'b1;
        hold_off_req   = 1'b0;

        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        foreach (recent_px[i])
            recent_px[i] = '0;
        foreach (filt_rows[i, j])
            filt_rows[i][j] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wide_frame();
        test_pixel_extremes();
        test_random_frames();
        test_register_change_mid_frame();
        test_output_backpressure();

        // wait_results_drained in each test already left the pipeline empty
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: ready pattern switches at random between always
    // ready, random stalls and a periodic stall; a hold-off request drops
    // ready for a long counted stretch.
    initial
    begin : receiver
        int unsigned mode_left;
        int unsigned tick;
        int unsigned period;
        stall_mode_t stall_mode;

        out_ready  = 1'b0;
        mode_left  = 0;
        tick       = 0;
        period     = 2;
        stall_mode = STALL_NONE;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 2));
                    mode_left  = $urandom_range(20, 300);
                    period     = $urandom_range(2, 6);
                end
                mode_left--;
                tick++;
                case (stall_mode)
                    STALL_NONE:   out_ready <= 1'b1;
                    STALL_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                    default:      out_ready <= ((tick % period) != 0);
                endcase
            end
        end
    end

    // Checker: each output transaction against the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reduced.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel %0d row_end %0b frame_end %0b",
                                          pixel_out, row_end, frame_end));
            end
            else
            begin
                want = pending_reduced.pop_front();
                if (pixel_out !== want.pixel || row_end !== want.row_end
                    || frame_end !== want.frame_end)
                begin
                    report_mismatch($sformatf(
                        "pixel %0d/%0b/%0b, expected %0d/%0b/%0b (pixel/row_end/frame_end)",
                        pixel_out, row_end, frame_end,
                        want.pixel, want.row_end, want.frame_end));
                end
            end
        end
    end

    // Watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                     WATCHDOG_LIMIT, pending_reduced.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;

endmodule

>>> sim.f
hdl/gpr_pkg.sv
hdl/gaussian_pyramid_reduce.sv
hdl/gpr_checker.sv
test/tb.sv
